### src/chol_pkg.sv
// Shared types and codes for the Cholesky factor and solve core.
// No dependencies; chol_dp, chol_ctrl and the top level import this package.
`default_nettype none
package chol_pkg;

  typedef enum logic [1:0] {
    OP_LOAD_MAT = 2'd0,
    OP_FACTOR   = 2'd1,
    OP_LOAD_RHS = 2'd2,
    OP_SOLVE    = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_NOT_SYM    = 2'd1,
    ST_NOT_PD     = 2'd2,
    ST_NOT_FACTOR = 2'd3
  } status_e;

  localparam logic KIND_STATUS   = 1'b0;
  localparam logic KIND_SOLUTION = 1'b1;

  typedef enum logic [1:0] {
    BASE_MAT = 2'd0,
    BASE_RHS = 2'd1,
    BASE_WRK = 2'd2
  } base_e;

  typedef enum logic [1:0] {
    PH_FACT = 2'd0,
    PH_FWD  = 2'd1,
    PH_BACK = 2'd2
  } phase_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SYM_A,
    S_SYM_B,
    S_SYM_C,
    S_F_INIT,
    S_RA,
    S_RB,
    S_MUL,
    S_ACC,
    S_BASE,
    S_LOAD,
    S_GO,
    S_WAIT,
    S_EMIT_RD,
    S_EMIT_OUT
  } state_e;

  typedef enum logic [1:0] {
    U_IDLE,
    U_DIV,
    U_SQRT,
    U_DIVFIN
  } unit_e;

  typedef struct packed {
    logic [1:0]        operation;
    logic [2:0]        row;
    logic [2:0]        col;
    logic signed [31:0] value;
  } req_t;

  typedef struct packed {
    logic              kind;
    logic [1:0]        status;
    logic [2:0]        index;
    logic signed [31:0] solution;
    logic              last;
  } res_t;

  typedef struct packed {
    logic       load_mat;
    logic       load_rhs;
    logic [2:0] mat_row;
    logic [2:0] mat_col;
    logic [2:0] fac_row;
    logic [2:0] fac_col;
    logic [2:0] vec_idx;
    logic       fac_we;
    logic       wrk_we;
    logic       lat_a;
    logic       a_from_mat;
    logic       mul;
    logic       b_from_wrk;
    logic       acc_clr;
    logic       acc_add;
    logic       load_d;
    base_e      base_sel;
    logic       div_start;
    logic       sqrt_start;
    logic       emit_stat;
    status_e    stat_code;
    logic       emit_sol;
    logic       last;
  } cmd_t;

  typedef struct packed {
    logic sym_eq;
    logic d_le0;
    logic unit_busy;
  } stat_t;

endpackage
`default_nettype wire

### src/chol_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module chol_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                                       clk_i,
  input  wire logic                                       we_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]                           wdata_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic      [WIDTH-1:0]                           rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

### src/chol_dp.sv
// Datapath: matrix, factor, rhs and work memories, multiply-accumulate,
// shared divide / square-root unit and result register. Uses chol_pkg, chol_ram.
`default_nettype none
module chol_dp import chol_pkg::*; #(
  parameter int MAX_N = 8
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire req_t req_i,
  input  wire cmd_t cmd_i,
  output stat_t     stat_o,
  output res_t      res_o,
  output logic      res_strobe_o
);

  localparam int MD  = MAX_N * MAX_N;
  localparam int MAW = (MD > 1) ? $clog2(MD) : 1;
  localparam int VAW = (MAX_N > 1) ? $clog2(MAX_N) : 1;

  logic               row_ok, col_ok, mat_we, rhs_we;
  logic [MAW-1:0]     mat_waddr, mat_raddr, fac_addr;
  logic [VAW-1:0]     vec_addr, rhs_waddr;
  logic signed [31:0] mat_rd, fac_rd, rhs_rd, wrk_rd;

  logic signed [31:0] a_q, g_q, ures_q;
  logic signed [63:0] prod_q, acc_q, d_q, rnd, base;
  logic signed [31:0] b_op;

  unit_e       ustate_q;
  logic [4:0]  cnt_q;
  logic        neg_q;
  logic [31:0] rem_q, quo_q;
  logic [25:0] srem_q;
  logic [23:0] root_q;
  logic [47:0] sq_q;

  logic [63:0] m_abs, g_shift;
  logic [32:0] dt, dnx;
  logic        dge;
  logic [27:0] st, strial, snx;
  logic        sge;
  logic [23:0] root_nx;
  logic signed [31:0] div_fin;

  assign row_ok    = int'(req_i.row) < MAX_N;
  assign col_ok    = int'(req_i.col) < MAX_N;
  assign mat_we    = cmd_i.load_mat && row_ok && col_ok;
  assign rhs_we    = cmd_i.load_rhs && row_ok;
  assign mat_waddr = MAW'(int'(req_i.row) * MAX_N + int'(req_i.col));
  assign rhs_waddr = VAW'(req_i.row);
  assign mat_raddr = MAW'(int'(cmd_i.mat_row) * MAX_N + int'(cmd_i.mat_col));
  assign fac_addr  = MAW'(int'(cmd_i.fac_row) * MAX_N + int'(cmd_i.fac_col));
  assign vec_addr  = VAW'(cmd_i.vec_idx);

  chol_ram #(.WIDTH(32), .DEPTH(MD)) u_mat (
    .clk_i, .we_i(mat_we), .waddr_i(mat_waddr), .wdata_i(req_i.value),
    .raddr_i(mat_raddr), .rdata_o(mat_rd)
  );

  chol_ram #(.WIDTH(32), .DEPTH(MD)) u_fac (
    .clk_i, .we_i(cmd_i.fac_we), .waddr_i(fac_addr), .wdata_i(ures_q),
    .raddr_i(fac_addr), .rdata_o(fac_rd)
  );

  chol_ram #(.WIDTH(32), .DEPTH(MAX_N)) u_rhs (
    .clk_i, .we_i(rhs_we), .waddr_i(rhs_waddr), .wdata_i(req_i.value),
    .raddr_i(vec_addr), .rdata_o(rhs_rd)
  );

  chol_ram #(.WIDTH(32), .DEPTH(MAX_N)) u_wrk (
    .clk_i, .we_i(cmd_i.wrk_we), .waddr_i(vec_addr), .wdata_i(ures_q),
    .raddr_i(vec_addr), .rdata_o(wrk_rd)
  );

  assign b_op = cmd_i.b_from_wrk ? wrk_rd : fac_rd;
  assign rnd  = (prod_q + 64'sd32768) >>> 16;

  always_comb begin
    case (cmd_i.base_sel)
      BASE_MAT: base = {{32{mat_rd[31]}}, mat_rd};
      BASE_RHS: base = {{32{rhs_rd[31]}}, rhs_rd};
      BASE_WRK: base = {{32{wrk_rd[31]}}, wrk_rd};
      default:  base = '0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.lat_a) begin
      a_q <= cmd_i.a_from_mat ? mat_rd : fac_rd;
    end
    if (cmd_i.mul) begin
      prod_q <= a_q * b_op;
    end
    if (cmd_i.acc_clr) begin
      acc_q <= '0;
    end else if (cmd_i.acc_add) begin
      acc_q <= acc_q + rnd;
    end
    if (cmd_i.load_d) begin
      d_q <= base - acc_q;
      g_q <= fac_rd;
    end
  end

  assign m_abs   = d_q[63] ? 64'(-d_q) : 64'(d_q);
  assign g_shift = {16'h0, g_q, 16'h0};

  assign dt  = {rem_q, quo_q[31]};
  assign dge = dt >= {1'b0, g_q};
  assign dnx = dge ? dt - {1'b0, g_q} : dt;

  assign st      = {srem_q, sq_q[47:46]};
  assign strial  = {2'b00, root_q, 2'b01};
  assign sge     = st >= strial;
  assign snx     = sge ? st - strial : st;
  assign root_nx = {root_q[22:0], sge};

  always_comb begin
    if (neg_q) begin
      div_fin = (quo_q >= 32'h8000_0000) ? 32'sh8000_0000 : -$signed(quo_q);
    end else begin
      div_fin = quo_q[31] ? 32'sh7fff_ffff : $signed(quo_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ustate_q <= U_IDLE;
      cnt_q    <= '0;
    end else begin
      case (ustate_q)
        U_IDLE: begin
          if (cmd_i.sqrt_start) begin
            ustate_q <= U_SQRT;
            cnt_q    <= 5'd23;
          end else if (cmd_i.div_start && g_q > 0 && m_abs < g_shift) begin
            ustate_q <= U_DIV;
            cnt_q    <= 5'd31;
          end
        end
        U_DIV: begin
          if (cnt_q == '0) begin
            ustate_q <= U_DIVFIN;
          end else begin
            cnt_q <= cnt_q - 5'd1;
          end
        end
        U_SQRT: begin
          if (cnt_q == '0) begin
            ustate_q <= U_IDLE;
          end else begin
            cnt_q <= cnt_q - 5'd1;
          end
        end
        U_DIVFIN: ustate_q <= U_IDLE;
        default:  ustate_q <= U_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (ustate_q)
      U_IDLE: begin
        if (cmd_i.sqrt_start) begin
          srem_q <= '0;
          root_q <= '0;
          sq_q   <= {d_q[31:0], 16'h0};
        end else if (cmd_i.div_start) begin
          neg_q <= d_q[63];
          if (g_q <= 0) begin
            ures_q <= '0;
          end else if (m_abs >= g_shift) begin
            ures_q <= d_q[63] ? 32'sh8000_0000 : 32'sh7fff_ffff;
          end else begin
            rem_q <= m_abs[47:16];
            quo_q <= {m_abs[15:0], 16'h0};
          end
        end
      end
      U_DIV: begin
        rem_q <= dnx[31:0];
        quo_q <= {quo_q[30:0], dge};
      end
      U_SQRT: begin
        srem_q <= snx[25:0];
        root_q <= root_nx;
        sq_q   <= {sq_q[45:0], 2'b00};
        if (cnt_q == '0) begin
          ures_q <= {8'h0, root_nx};
        end
      end
      U_DIVFIN: ures_q <= div_fin;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_strobe_o <= 1'b0;
    end else begin
      res_strobe_o <= cmd_i.emit_stat || cmd_i.emit_sol;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit_stat) begin
      res_o.kind     <= KIND_STATUS;
      res_o.status   <= cmd_i.stat_code;
      res_o.index    <= '0;
      res_o.solution <= '0;
      res_o.last     <= 1'b1;
    end else if (cmd_i.emit_sol) begin
      res_o.kind     <= KIND_SOLUTION;
      res_o.status   <= ST_OK;
      res_o.index    <= cmd_i.vec_idx;
      res_o.solution <= wrk_rd;
      res_o.last     <= cmd_i.last;
    end
  end

  assign stat_o.sym_eq    = mat_rd == a_q;
  assign stat_o.d_le0     = d_q <= 64'sd0;
  assign stat_o.unit_busy = ustate_q != U_IDLE;

`ifndef SYNTH
  a_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.emit_stat || cmd_i.emit_sol) |=> res_strobe_o)
    else $error("result strobe missing after emit");
  a_div_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ustate_q == U_IDLE && cmd_i.div_start && g_q <= 0) |=> !stat_o.unit_busy)
    else $error("divide by non-positive divisor started iteration");
  a_sqrt_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ustate_q == U_IDLE && cmd_i.sqrt_start) |=> (ustate_q == U_SQRT))
    else $error("square root did not start");
`endif

endmodule
`default_nettype wire

### src/chol_ctrl.sv
// Controller: request decode, loop counters and sequencing of the
// symmetry check, factor, substitution and result emission. Uses chol_pkg.
`default_nettype none
module chol_ctrl import chol_pkg::*; #(
  parameter int MAX_N = 8
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       start_i,
  input  wire logic [1:0] op_i,
  input  wire logic       cfg_we_i,
  input  wire logic [3:0] cfg_wdata_i,
  input  wire stat_t      stat_i,
  output logic            busy_o,
  output cmd_t            cmd_o
);

  localparam int NMAX = (MAX_N < 8) ? MAX_N : 8;

  state_e     state_q, state_d;
  phase_e     phase_q, phase_d;
  logic [3:0] i_q, i_d, j_q, j_d, k_q, k_d, size_q, size_d;
  logic       fact_q, fact_d;
  logic [3:0] n, limit, j_init;
  logic       accept;

  always_comb begin
    if (size_q == 4'd0) begin
      n = 4'd1;
    end else if (size_q > 4'(NMAX)) begin
      n = 4'(NMAX);
    end else begin
      n = size_q;
    end
  end

  assign limit  = (phase_q == PH_BACK) ? n : i_q;
  assign j_init = (phase_q == PH_BACK) ? i_q + 4'd1 : 4'd0;
  assign busy_o = state_q != S_IDLE;
  assign accept = start_i && state_q == S_IDLE;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      phase_q <= PH_FACT;
      i_q     <= '0;
      j_q     <= '0;
      k_q     <= '0;
      size_q  <= 4'd8;
      fact_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      phase_q <= phase_d;
      i_q     <= i_d;
      j_q     <= j_d;
      k_q     <= k_d;
      size_q  <= size_d;
      fact_q  <= fact_d;
    end
  end

  always_comb begin
    state_d = state_q;
    phase_d = phase_q;
    i_d     = i_q;
    j_d     = j_q;
    k_d     = k_q;
    size_d  = size_q;
    fact_d  = fact_q;
    cmd_o   = '0;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          case (op_i)
            OP_LOAD_MAT: cmd_o.load_mat = 1'b1;
            OP_LOAD_RHS: cmd_o.load_rhs = 1'b1;
            OP_FACTOR: begin
              i_d = '0;
              if (n < 4'd2) begin
                phase_d = PH_FACT;
                k_d     = '0;
                state_d = S_F_INIT;
              end else begin
                j_d     = 4'd1;
                state_d = S_SYM_A;
              end
            end
            OP_SOLVE: begin
              if (!fact_q) begin
                cmd_o.emit_stat = 1'b1;
                cmd_o.stat_code = ST_NOT_FACTOR;
              end else begin
                phase_d = PH_FWD;
                i_d     = '0;
                state_d = S_F_INIT;
              end
            end
            default: ;
          endcase
        end
      end
      S_SYM_A: begin
        cmd_o.mat_row = i_q[2:0];
        cmd_o.mat_col = j_q[2:0];
        state_d       = S_SYM_B;
      end
      S_SYM_B: begin
        cmd_o.lat_a      = 1'b1;
        cmd_o.a_from_mat = 1'b1;
        cmd_o.mat_row    = j_q[2:0];
        cmd_o.mat_col    = i_q[2:0];
        state_d          = S_SYM_C;
      end
      S_SYM_C: begin
        if (!stat_i.sym_eq) begin
          cmd_o.emit_stat = 1'b1;
          cmd_o.stat_code = ST_NOT_SYM;
          fact_d          = 1'b0;
          state_d         = S_IDLE;
        end else if (j_q + 4'd1 < n) begin
          j_d     = j_q + 4'd1;
          state_d = S_SYM_A;
        end else if (i_q + 4'd2 < n) begin
          i_d     = i_q + 4'd1;
          j_d     = i_q + 4'd2;
          state_d = S_SYM_A;
        end else begin
          phase_d = PH_FACT;
          i_d     = '0;
          k_d     = '0;
          state_d = S_F_INIT;
        end
      end
      S_F_INIT: begin
        cmd_o.acc_clr = 1'b1;
        j_d           = j_init;
        state_d       = (j_init < limit) ? S_RA : S_BASE;
      end
      S_RA: begin
        cmd_o.fac_row = (phase_q == PH_BACK) ? j_q[2:0] : i_q[2:0];
        cmd_o.fac_col = (phase_q == PH_BACK) ? i_q[2:0] : j_q[2:0];
        state_d       = S_RB;
      end
      S_RB: begin
        cmd_o.lat_a   = 1'b1;
        cmd_o.fac_row = k_q[2:0];
        cmd_o.fac_col = j_q[2:0];
        cmd_o.vec_idx = j_q[2:0];
        state_d       = S_MUL;
      end
      S_MUL: begin
        cmd_o.mul        = 1'b1;
        cmd_o.b_from_wrk = phase_q != PH_FACT;
        state_d          = S_ACC;
      end
      S_ACC: begin
        cmd_o.acc_add = 1'b1;
        j_d           = j_q + 4'd1;
        state_d       = (j_q + 4'd1 < limit) ? S_RA : S_BASE;
      end
      S_BASE: begin
        cmd_o.fac_row = i_q[2:0];
        cmd_o.fac_col = i_q[2:0];
        cmd_o.mat_row = k_q[2:0];
        cmd_o.mat_col = i_q[2:0];
        cmd_o.vec_idx = i_q[2:0];
        state_d       = S_LOAD;
      end
      S_LOAD: begin
        cmd_o.load_d = 1'b1;
        case (phase_q)
          PH_FACT: cmd_o.base_sel = BASE_MAT;
          PH_FWD:  cmd_o.base_sel = BASE_RHS;
          default: cmd_o.base_sel = BASE_WRK;
        endcase
        state_d = S_GO;
      end
      S_GO: begin
        if (phase_q == PH_FACT && i_q == k_q) begin
          if (stat_i.d_le0) begin
            cmd_o.emit_stat = 1'b1;
            cmd_o.stat_code = ST_NOT_PD;
            fact_d          = 1'b0;
            state_d         = S_IDLE;
          end else begin
            cmd_o.sqrt_start = 1'b1;
            state_d          = S_WAIT;
          end
        end else begin
          cmd_o.div_start = 1'b1;
          state_d         = S_WAIT;
        end
      end
      S_WAIT: begin
        cmd_o.fac_row = k_q[2:0];
        cmd_o.fac_col = i_q[2:0];
        cmd_o.vec_idx = i_q[2:0];
        if (!stat_i.unit_busy) begin
          case (phase_q)
            PH_FACT: begin
              cmd_o.fac_we = 1'b1;
              if (i_q < k_q) begin
                i_d     = i_q + 4'd1;
                state_d = S_F_INIT;
              end else if (k_q + 4'd1 < n) begin
                k_d     = k_q + 4'd1;
                i_d     = '0;
                state_d = S_F_INIT;
              end else begin
                cmd_o.emit_stat = 1'b1;
                cmd_o.stat_code = ST_OK;
                fact_d          = 1'b1;
                state_d         = S_IDLE;
              end
            end
            PH_FWD: begin
              cmd_o.wrk_we = 1'b1;
              if (i_q + 4'd1 < n) begin
                i_d = i_q + 4'd1;
              end else begin
                phase_d = PH_BACK;
                i_d     = n - 4'd1;
              end
              state_d = S_F_INIT;
            end
            default: begin
              cmd_o.wrk_we = 1'b1;
              if (i_q != 4'd0) begin
                i_d     = i_q - 4'd1;
                state_d = S_F_INIT;
              end else begin
                state_d = S_EMIT_RD;
              end
            end
          endcase
        end
      end
      S_EMIT_RD: begin
        cmd_o.vec_idx = i_q[2:0];
        state_d       = S_EMIT_OUT;
      end
      S_EMIT_OUT: begin
        cmd_o.vec_idx  = i_q[2:0];
        cmd_o.emit_sol = 1'b1;
        cmd_o.last     = i_q + 4'd1 == n;
        if (i_q + 4'd1 < n) begin
          i_d     = i_q + 4'd1;
          state_d = S_EMIT_RD;
        end else begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase

    if (cfg_we_i) begin
      size_d = cfg_wdata_i;
      fact_d = 1'b0;
    end
  end

`ifndef SYNTH
  a_idle_no_unit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> !(cmd_o.div_start || cmd_o.sqrt_start))
    else $error("arithmetic unit started from idle");
  a_sol_factored: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.emit_sol |-> fact_q)
    else $error("solution emitted without a valid factor");
  a_stat_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.emit_stat && !cfg_we_i) |=> (state_q == S_IDLE))
    else $error("status report did not end the command");
`endif

endmodule
`default_nettype wire

### src/cholesky_factor_and_solve_core.sv
// Top level of the Cholesky factor and solve core: controller plus datapath.
// Uses chol_pkg, chol_ctrl, chol_dp (and chol_ram through the datapath).
//
// A request is taken when start is high and busy is low. Matrix and rhs
// loads give no result. A factor request walks the matrix: it first checks
// each symmetric pair, then for each factor entry accumulates the products
// and runs the shared divide/square-root unit; it ends with one status
// result. A solve of a factored matrix runs the same loop for forward and
// back substitution, then emits x[0]..x[n-1], last marked; without a factor
// it gives a not-factored status. Each result shows on res_o for exactly
// one cycle with res_strobe_o and must be taken then; the receiver cannot
// stall. Matrix size writes clear the factored state.
`default_nettype none
module cholesky_factor_and_solve_core import chol_pkg::*; #(
  parameter int MAX_N = 8
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       start,
  output logic            busy,
  input  wire req_t       req_i,
  input  wire logic       cfg_we_i,
  input  wire logic [3:0] cfg_wdata_i,
  output res_t            res_o,
  output logic            res_strobe_o
);

  cmd_t  cmd;
  stat_t stat;

  chol_ctrl #(.MAX_N(MAX_N)) u_ctrl (
    .clk_i, .rst_ni,
    .start_i(start),
    .op_i(req_i.operation),
    .cfg_we_i, .cfg_wdata_i,
    .stat_i(stat),
    .busy_o(busy),
    .cmd_o(cmd)
  );

  chol_dp #(.MAX_N(MAX_N)) u_dp (
    .clk_i, .rst_ni,
    .req_i,
    .cmd_i(cmd),
    .stat_o(stat),
    .res_o,
    .res_strobe_o
  );

endmodule
`default_nettype wire
